[rtl/lrupp_pkg.sv]
`default_nettype none

package lrupp_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W    = 64;
    localparam int DRAW_W   = 16;
    localparam int FACTOR_W = 17;

    // Fraction bits of the promotion factor and of the random draw
    localparam int Q_FRAC = 16;

    // Promotion factor after reset: 0.5 in Q16
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd32768;

    // Request codes
    localparam logic CMD_GET    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

endpackage

`default_nettype wire

[rtl/lru_probabilistic_promotion.sv]
`default_nettype none

// Fully associative LRU directory with probabilistic promotion. Each entry
// holds a key, a valid bit, a recency rank (0 = most recent) and a promotion
// scaler in Q(SCALE_BITS). A get that hits moves the entry to the front only
// when the aligned random draw is below the entry's scaler. The scaler then
// becomes max(scaler * factor, 0.1), capped at 1.0. A get that misses
// inserts the key at the front with scaler 1.0, and evicts the least recent
// entry when all ENTRIES slots are full. A remove drops the key if present.
// The block takes one request per clock while results are taken and returns
// one result per request. A request passes through the input register and
// the result register. The rate is set by the pass through the register CAM:
// a parallel key compare, the rank update of every entry and one scaler
// multiply. The user must write the promotion factor through i_cfg_we and
// i_cfg_wdata only while no request is in flight; the block does not enforce it.
module lru_probabilistic_promotion #(
    parameter int ENTRIES    = 64,
    parameter int SCALE_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_we,
    input  wire  [lrupp_pkg::FACTOR_W-1:0]      i_cfg_wdata,
    // request channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_cmd,
    input  wire  [lrupp_pkg::KEY_W-1:0]         i_key,
    input  wire  [lrupp_pkg::DRAW_W-1:0]        i_random_draw,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_hit,
    output logic                                o_promoted,
    output logic                                o_evicted_valid,
    output logic [lrupp_pkg::KEY_W-1:0]         o_evicted_key,
    output logic                                o_removed
);

    import lrupp_pkg::*;

    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int SCL_W   = SCALE_BITS + 1;
    localparam int PROD_W  = SCL_W + FACTOR_W;
    localparam int DRAW_SHL = (SCALE_BITS >= Q_FRAC) ? SCALE_BITS - Q_FRAC : 0;
    localparam int DRAW_SHR = (SCALE_BITS >= Q_FRAC) ? 0 : Q_FRAC - SCALE_BITS;
    localparam int DEXT_W  = SCL_W + DRAW_W;

    localparam logic [SCL_W-1:0]  SCALER_ONE   = SCL_W'(1) << SCALE_BITS;
    localparam logic [SCL_W-1:0]  SCALER_FLOOR = SCL_W'(((2 ** SCALE_BITS) + 5) / 10);
    localparam logic [RANK_W-1:0] RANK_LAST    = RANK_W'(ENTRIES - 1);
    localparam logic [OCC_W-1:0]  OCC_FULL     = OCC_W'(ENTRIES);

    // Configuration
    logic [FACTOR_W-1:0] r_factor;

    // Input register
    logic               r_in_valid;
    logic               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [DRAW_W-1:0]  r_draw;

    // Directory storage
    logic [KEY_W-1:0]   r_ent_key    [ENTRIES];
    logic [SCL_W-1:0]   r_ent_scaler [ENTRIES];
    logic [RANK_W-1:0]  r_ent_rank   [ENTRIES];
    logic [ENTRIES-1:0] r_ent_valid;
    logic [OCC_W-1:0]   r_occ;

    // Lookup and update terms
    logic               w_fire;
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_lru_oh;
    logic [ENTRIES-1:0] w_free_oh;
    logic [ENTRIES-1:0] w_ins_oh;
    logic               w_hit;
    logic               w_full;
    logic [RANK_W-1:0]  w_hit_rank;
    logic [SCL_W-1:0]   w_hit_scaler;
    logic [KEY_W-1:0]   w_lru_key;
    logic [DEXT_W-1:0]  w_draw_ext;
    logic [SCL_W-1:0]   w_draw_al;
    logic               w_promote;
    logic [PROD_W-1:0]  w_prod;
    logic [SCL_W:0]     w_prod_q;
    logic [SCL_W-1:0]   w_new_scaler;
    logic               w_get;
    logic               w_evict;

    // Result register
    logic               r_out_valid;
    logic               r_hit;
    logic               r_promoted;
    logic               r_evicted_valid;
    logic [KEY_W-1:0]   r_evicted_key;
    logic               r_removed;

    // Handshake: the pass fires when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // Hold the promotion factor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (i_cfg_we) begin
            r_factor <= i_cfg_wdata;
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_cmd;
            r_key  <= i_key;
            r_draw <= i_random_draw;
        end
    end

    // Match every entry, locate the least recent and the first free slot
    always_comb begin
        logic found;
        found        = 1'b0;
        w_hit_rank   = '0;
        w_hit_scaler = '0;
        w_lru_key    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i]   = r_ent_valid[i] && (r_ent_key[i] == r_key);
            w_lru_oh[i]  = r_ent_valid[i] && (r_ent_rank[i] == RANK_LAST);
            w_free_oh[i] = !r_ent_valid[i] && !found;
            found        = found || !r_ent_valid[i];
            w_hit_rank   = w_hit_rank   | ({RANK_W{w_match[i]}} & r_ent_rank[i]);
            w_hit_scaler = w_hit_scaler | ({SCL_W{w_match[i]}} & r_ent_scaler[i]);
            w_lru_key    = w_lru_key    | ({KEY_W{w_lru_oh[i]}} & r_ent_key[i]);
        end
    end

    assign w_hit    = |w_match;
    assign w_full   = (r_occ == OCC_FULL);
    assign w_ins_oh = w_full ? w_lru_oh : w_free_oh;
    assign w_get    = (r_cmd == CMD_GET);
    assign w_evict  = w_get && !w_hit && w_full;

    // Align the draw to the scaler format and decide promotion
    assign w_draw_ext = (DEXT_W'(r_draw) << DRAW_SHL) >> DRAW_SHR;
    assign w_draw_al  = w_draw_ext[SCL_W-1:0];
    assign w_promote  = w_get && w_hit && (w_draw_al < w_hit_scaler);

    // Scale the scaler, then clamp to [floor, 1.0]
    assign w_prod   = PROD_W'(w_hit_scaler) * PROD_W'(r_factor);
    assign w_prod_q = w_prod[PROD_W-1:Q_FRAC];

    always_comb begin
        if (w_prod_q > (SCL_W + 1)'(SCALER_ONE)) begin
            w_new_scaler = SCALER_ONE;
        end else if (w_prod_q < (SCL_W + 1)'(SCALER_FLOOR)) begin
            w_new_scaler = SCALER_FLOOR;
        end else begin
            w_new_scaler = w_prod_q[SCL_W-1:0];
        end
    end

    // Update key, scaler and rank of every entry
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_cmd == CMD_REMOVE) begin
                    // close the gap left by the removed entry
                    if (w_hit && r_ent_valid[i] && (r_ent_rank[i] > w_hit_rank)) begin
                        r_ent_rank[i] <= r_ent_rank[i] - RANK_W'(1);
                    end
                end else if (w_hit) begin
                    if (w_promote) begin
                        if (w_match[i]) begin
                            r_ent_rank[i]   <= '0;
                            r_ent_scaler[i] <= w_new_scaler;
                        end else if (r_ent_valid[i] && (r_ent_rank[i] < w_hit_rank)) begin
                            r_ent_rank[i] <= r_ent_rank[i] + RANK_W'(1);
                        end
                    end
                end else begin
                    // insert at the front, age the rest
                    if (w_ins_oh[i]) begin
                        r_ent_key[i]    <= r_key;
                        r_ent_scaler[i] <= SCALER_ONE;
                        r_ent_rank[i]   <= '0;
                    end else if (r_ent_valid[i]) begin
                        r_ent_rank[i] <= r_ent_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // Valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_occ       <= '0;
        end else if (w_fire) begin
            if (r_cmd == CMD_REMOVE) begin
                if (w_hit) begin
                    r_ent_valid <= r_ent_valid & ~w_match;
                    r_occ       <= r_occ - OCC_W'(1);
                end
            end else if (!w_hit) begin
                r_ent_valid <= r_ent_valid | w_ins_oh;
                if (!w_full) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
            end
        end
    end

    // Result register: load on fire, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit           <= w_hit;
            r_promoted      <= w_promote;
            r_evicted_valid <= w_evict;
            r_evicted_key   <= w_evict ? w_lru_key : '0;
            r_removed       <= (r_cmd == CMD_REMOVE) && w_hit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_promoted      = r_promoted;
    assign o_evicted_valid = r_evicted_valid;
    assign o_evicted_key   = r_evicted_key;
    assign o_removed       = r_removed;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_FULL)
        else $error("occupancy above directory size");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_ent_valid) == int'(r_occ))
        else $error("occupancy differs from number of valid entries");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(w_match))
        else $error("key present in more than one entry");

    a_promote_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_promoted || o_hit) && !(o_evicted_valid && o_hit))
        else $error("result flags inconsistent");
`endif

endmodule

`default_nettype wire

[tb/lru_probabilistic_promotion_tb.sv]
module lru_probabilistic_promotion_tb;
    import lrupp_pkg::*;

    localparam int DIR_DEPTH     = 64;
    localparam int SCALE_BITS    = 16;
    localparam int SCALE_W       = SCALE_BITS + 1;
    localparam int PROD_W        = SCALE_W + FACTOR_W;
    localparam int PHASE_ITEMS   = 107;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [PROD_W-1:0] SCALE_ONE   = PROD_W'(1) << SCALE_BITS;
    localparam logic [PROD_W-1:0] SCALE_FLOOR = (SCALE_ONE + 5) / 10;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [DRAW_W-1:0] draw;
    } t_request;

    typedef struct packed {
        logic             hit;
        logic             promoted;
        logic             evicted_valid;
        logic [KEY_W-1:0] evicted_key;
        logic             removed;
    } t_outcome;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} t_rx_style;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [FACTOR_W-1:0] i_cfg_wdata   = '0;
    logic                i_in_valid    = 1'b0;
    logic                i_cmd         = CMD_GET;
    logic [KEY_W-1:0]    i_key         = '0;
    logic [DRAW_W-1:0]   i_random_draw = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_hit;
    logic                o_promoted;
    logic                o_evicted_valid;
    logic [KEY_W-1:0]    o_evicted_key;
    logic                o_removed;

    // Directory mirror used for prediction
    logic [KEY_W-1:0]    dir_key   [DIR_DEPTH];
    logic                dir_valid [DIR_DEPTH];
    logic [SCALE_W-1:0]  dir_scale [DIR_DEPTH];
    int                  dir_rank  [DIR_DEPTH];
    int                  dir_count;
    logic [FACTOR_W-1:0] factor_q16;

    t_request  pending_q [$];
    t_outcome  outcome_q [$];
    int        reqs_sent    = 0;
    int        reqs_taken   = 0;
    int        results_seen = 0;
    int        err_count    = 0;
    int        stuck_cycles = 0;
    logic      req_beat     = 1'b0;
    int        burst_left   = 0;
    int        gap_left     = 0;
    int        rx_tick      = 0;
    t_rx_style rx_style     = RX_OPEN;

    lru_probabilistic_promotion #(
        .ENTRIES    (DIR_DEPTH),
        .SCALE_BITS (SCALE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_key           (i_key),
        .i_random_draw   (i_random_draw),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_promoted      (o_promoted),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_removed       (o_removed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic log_error(input string msg);
        err_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Apply one request to the directory mirror and return its outcome
    function automatic t_outcome predict_access(input t_request rq);
        t_outcome          res;
        int                i;
        int                slot;
        int                victim;
        int                r;
        logic [PROD_W-1:0] prod;
        res  = '0;
        slot = -1;
        for (i = 0; i < DIR_DEPTH; i++) begin
            if (slot < 0 && dir_valid[i] && dir_key[i] == rq.key) begin
                slot = i;
            end
        end
        if (rq.cmd == CMD_REMOVE) begin
            // Drop the key and close the gap in the recency order
            if (slot >= 0) begin
                r = dir_rank[slot];
                res.hit     = 1'b1;
                res.removed = 1'b1;
                dir_valid[slot] = 1'b0;
                for (i = 0; i < DIR_DEPTH; i++) begin
                    if (dir_valid[i] && dir_rank[i] > r) begin
                        dir_rank[i]--;
                    end
                end
                if (dir_count > 0) begin
                    dir_count--;
                end
            end
        end else if (slot >= 0) begin
            // Promote only when the draw falls below the entry's scaler
            res.hit = 1'b1;
            if (PROD_W'(rq.draw) < PROD_W'(dir_scale[slot])) begin
                prod = dir_scale[slot] * factor_q16;
                prod = prod >> Q_FRAC;
                if (prod > SCALE_ONE) begin
                    prod = SCALE_ONE;
                end
                if (prod < SCALE_FLOOR) begin
                    prod = SCALE_FLOOR;
                end
                res.promoted = 1'b1;
                r = dir_rank[slot];
                for (i = 0; i < DIR_DEPTH; i++) begin
                    if (dir_valid[i] && i != slot && dir_rank[i] < r) begin
                        dir_rank[i]++;
                    end
                end
                dir_rank[slot]  = 0;
                dir_scale[slot] = prod[SCALE_W-1:0];
            end
        end else begin
            // Miss: evict the least recent entry when full, then insert at front
            victim = -1;
            if (dir_count >= DIR_DEPTH) begin
                for (i = 0; i < DIR_DEPTH; i++) begin
                    if (victim < 0 && dir_valid[i] && dir_rank[i] == dir_count - 1) begin
                        victim = i;
                    end
                end
                if (victim >= 0) begin
                    res.evicted_valid = 1'b1;
                    res.evicted_key   = dir_key[victim];
                    dir_valid[victim] = 1'b0;
                    dir_count--;
                end
            end
            if (victim < 0) begin
                for (i = 0; i < DIR_DEPTH; i++) begin
                    if (victim < 0 && !dir_valid[i]) begin
                        victim = i;
                    end
                end
            end
            if (victim >= 0) begin
                for (i = 0; i < DIR_DEPTH; i++) begin
                    if (dir_valid[i]) begin
                        dir_rank[i]++;
                    end
                end
                dir_valid[victim] = 1'b1;
                dir_key[victim]   = rq.key;
                dir_scale[victim] = SCALE_ONE[SCALE_W-1:0];
                dir_rank[victim]  = 0;
                dir_count++;
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_request(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic [DRAW_W-1:0] draw);
        t_request rq;
        rq.cmd  = cmd;
        rq.key  = key;
        rq.draw = draw;
        pending_q.push_back(rq);
        reqs_sent++;
    endtask

    // Mostly gets over a working set of keys, plus removes and stray keys
    task automatic queue_random(input int n);
        logic [KEY_W-1:0]  pool [$];
        logic [DRAW_W-1:0] d;
        int                pool_n;
        int                k;
        int                pick;
        pool_n = $urandom_range(12, 120);
        for (k = 0; k < pool_n; k++) begin
            pool.push_back(rand_key());
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 6))
                    0:       d = 16'd0;
                    1:       d = 16'd1;
                    2:       d = 16'd6553;
                    3:       d = 16'd6554;
                    4:       d = 16'd32767;
                    5:       d = 16'd32768;
                    default: d = 16'hFFFF;
                endcase
            end else begin
                d = DRAW_W'($urandom_range(0, 65535));
            end
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                queue_request(CMD_GET, pool[$urandom_range(0, pool_n - 1)], d);
            end else if (pick < 16) begin
                queue_request(CMD_GET, rand_key(), d);
            end else if (pick < 19) begin
                queue_request(CMD_REMOVE, pool[$urandom_range(0, pool_n - 1)], d);
            end else begin
                queue_request(CMD_REMOVE, rand_key(), d);
            end
        end
    endtask

    // Wait until every request is answered, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (reqs_taken != reqs_sent || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Request driver: bursts of beats separated by random gaps
    always @(negedge i_clk) begin : req_driver
        t_request rq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_beat) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                rq = pending_q.pop_front();
                i_cmd         <= rq.cmd;
                i_key         <= rq.key;
                i_random_draw <= rq.draw;
                i_in_valid    <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result backpressure: switch between randomly chosen stall styles
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 40 == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
        end
        case (rx_style)
            RX_OPEN:     i_out_ready <= 1'b1;
            RX_SPARSE:   i_out_ready <= ($urandom_range(0, 4) != 0);
            RX_PERIODIC: i_out_ready <= ((rx_tick % 8) >= 3);
            default:     i_out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Monitor: check result beats, then predict accepted request beats
    always @(posedge i_clk) begin : beat_monitor
        t_outcome got;
        t_outcome exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.hit           = o_hit;
            got.promoted      = o_promoted;
            got.evicted_valid = o_evicted_valid;
            got.evicted_key   = o_evicted_key;
            got.removed       = o_removed;
            results_seen++;
            if (outcome_q.size() == 0) begin
                log_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                exp_res = outcome_q.pop_front();
                if (got.hit !== exp_res.hit)
                    log_error($sformatf("result %0d hit %b, expected %b",
                                        results_seen, got.hit, exp_res.hit));
                if (got.promoted !== exp_res.promoted)
                    log_error($sformatf("result %0d promoted %b, expected %b",
                                        results_seen, got.promoted, exp_res.promoted));
                if (got.evicted_valid !== exp_res.evicted_valid)
                    log_error($sformatf("result %0d evicted_valid %b, expected %b",
                                        results_seen, got.evicted_valid,
                                        exp_res.evicted_valid));
                if (got.evicted_key !== exp_res.evicted_key)
                    log_error($sformatf("result %0d evicted_key %h, expected %h",
                                        results_seen, got.evicted_key,
                                        exp_res.evicted_key));
                if (got.removed !== exp_res.removed)
                    log_error($sformatf("result %0d removed %b, expected %b",
                                        results_seen, got.removed, exp_res.removed));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            outcome_q.push_back(predict_access('{i_cmd, i_key, i_random_draw}));
            reqs_taken++;
        end
        req_beat <= i_rst_n && i_in_valid && o_in_ready;
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, outcome_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [FACTOR_W-1:0] plan [6];
        int                  i;
        int                  p;
        factor_q16 = FACTOR_RESET;
        dir_count  = 0;
        for (i = 0; i < DIR_DEPTH; i++) begin
            dir_key[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_scale[i] = '0;
            dir_rank[i]  = 0;
        end
        plan[0] = '0;
        plan[1] = 17'd65536;
        plan[2] = 17'h1FFFF;
        plan[3] = 17'd1;
        plan[4] = FACTOR_W'($urandom_range(2, 65535));
        plan[5] = FACTOR_RESET;

        // Hold reset, release on a falling edge
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: key extremes, scaler decay down to the floor, hit without
        // promotion, removes of present and absent keys
        queue_request(CMD_GET,    64'h0,                   16'h0000);
        queue_request(CMD_GET,    64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        queue_request(CMD_GET,    64'h0,                   16'hFFFF);
        queue_request(CMD_GET,    64'h0,                   16'd32768);
        queue_request(CMD_GET,    64'h0,                   16'd32767);
        queue_request(CMD_GET,    64'h0,                   16'd0);
        queue_request(CMD_GET,    64'h0,                   16'd0);
        queue_request(CMD_GET,    64'h0,                   16'd6553);
        queue_request(CMD_GET,    64'h0,                   16'd6554);
        queue_request(CMD_GET,    64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
        queue_request(CMD_REMOVE, 64'h5555_5555_5555_5555, 16'd0);
        queue_request(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        queue_request(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
        queue_request(CMD_GET,    64'h8000_0000_0000_0000, 16'd1);
        queue_request(CMD_GET,    64'h1,                   16'hFFFE);
        queue_request(CMD_GET,    64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
        queue_request(CMD_GET,    64'h5555_5555_5555_5555, 16'hAAAA);
        queue_request(CMD_REMOVE, 64'h0,                   16'h5555);
        queue_request(CMD_GET,    64'h8000_0000_0000_0000, 16'd0);
        queue_request(CMD_GET,    64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF);
        queue_request(CMD_REMOVE, 64'h1,                   16'hAAAA);
        queue_random(PHASE_ITEMS);

        // Step through factor settings, writing only while the block is idle
        for (p = 0; p < 6; p++) begin
            wait_drained();
            @(negedge i_clk);
            i_cfg_we    = 1'b1;
            i_cfg_wdata = plan[p];
            factor_q16  = plan[p];
            @(negedge i_clk);
            i_cfg_we    = 1'b0;
            queue_random(PHASE_ITEMS);
        end
        wait_drained();

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lrupp_pkg.sv
rtl/lru_probabilistic_promotion.sv
tb/lru_probabilistic_promotion_tb.sv
